FILE: design/temperature_to_seven_segment_scanner_core_assert.svh
// assertion macros for the temperature scanner core
// used by the top level only; no dependencies
`ifndef TEMPERATURE_TO_SEVEN_SEGMENT_SCANNER_CORE_ASSERT_SVH
`define TEMPERATURE_TO_SEVEN_SEGMENT_SCANNER_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define TTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tts: implication check failed");

// condition implies consequence in the next cycle
`define TTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tts: next-cycle check failed");

`endif

FILE: design/tts_pkg.sv
// shared types, constants and lookup functions for the temperature scanner
// no dependencies
package tts_pkg;

   localparam int DIGIT_COUNT_DEFAULT = 8;
   localparam int MAX_DIGITS          = 8;
   localparam int CODE_W              = 5;
   localparam int POS_W               = 3;
   localparam int SEG_W               = 8;
   localparam int BYTE_W              = 8;

   typedef logic [CODE_W-1:0] code_type;
   typedef code_type [MAX_DIGITS-1:0] code_array_type;

   // digit codes: 0..15 glyphs, then blank and minus
   localparam code_type CODE_BLANK = 5'd16;
   localparam code_type CODE_MINUS = 5'd17;

   // request kinds
   localparam logic REQ_TICK    = 1'b0;
   localparam logic REQ_READING = 1'b1;

   localparam logic [BYTE_W-1:0] SIGN_MASK = 8'hf8;
   localparam logic [SEG_W-1:0]  DP_SEG    = 8'h80;
   localparam logic [POS_W-1:0]  DP_DIGIT  = 3'd2;

   // divide by ten for values below 100: (x * 205) >> 11
   localparam logic [7:0] DIV10_MUL   = 8'd205;
   localparam int         DIV10_SHIFT = 11;

   // commands from the input stage to the scan stage
   typedef struct packed {
      logic load;
      logic tick;
   } scan_cmd_type;

   // segment pattern for a digit code, unused codes dark
   function automatic logic [SEG_W-1:0] glyph(input code_type code);
      logic [SEG_W-1:0] seg;
      case (code)
         5'd0:       seg = 8'h3f;
         5'd1:       seg = 8'h06;
         5'd2:       seg = 8'h5b;
         5'd3:       seg = 8'h4f;
         5'd4:       seg = 8'h66;
         5'd5:       seg = 8'h6d;
         5'd6:       seg = 8'h7d;
         5'd7:       seg = 8'h07;
         5'd8:       seg = 8'h7f;
         5'd9:       seg = 8'h6f;
         5'd10:      seg = 8'h77;
         5'd11:      seg = 8'h7c;
         5'd12:      seg = 8'h39;
         5'd13:      seg = 8'h5e;
         5'd14:      seg = 8'h79;
         5'd15:      seg = 8'h71;
         CODE_BLANK: seg = 8'h00;
         CODE_MINUS: seg = 8'h40;
         default:    seg = 8'h00;
      endcase
      return seg;
   endfunction

   // a fraction in sixteenths as hundredths, two bcd digits {tens, ones}
   function automatic logic [7:0] frac_bcd(input logic [3:0] frac);
      logic [7:0] bcd;
      case (frac)
         4'd0:    bcd = 8'h00;
         4'd1:    bcd = 8'h06;
         4'd2:    bcd = 8'h12;
         4'd3:    bcd = 8'h19;
         4'd4:    bcd = 8'h25;
         4'd5:    bcd = 8'h31;
         4'd6:    bcd = 8'h38;
         4'd7:    bcd = 8'h44;
         4'd8:    bcd = 8'h50;
         4'd9:    bcd = 8'h56;
         4'd10:   bcd = 8'h63;
         4'd11:   bcd = 8'h69;
         4'd12:   bcd = 8'h75;
         4'd13:   bcd = 8'h81;
         4'd14:   bcd = 8'h88;
         4'd15:   bcd = 8'h94;
         default: bcd = 8'h00;
      endcase
      return bcd;
   endfunction

endpackage

FILE: design/tts_req_if.sv
// request channel: scan ticks and temperature readings
// depends on tts_pkg
interface tts_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [tts_pkg::BYTE_W-1:0]    reading_low;
   logic [tts_pkg::BYTE_W-1:0]    reading_high;

   modport source (output valid, output req_type, output reading_low,
                   output reading_high, input ready);
   modport sink   (input valid, input req_type, input reading_low,
                   input reading_high, output ready);
endinterface

FILE: design/tts_rsp_if.sv
// response channel: one digit drive per scan tick
// depends on tts_pkg
interface tts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tts_pkg::SEG_W-1:0]     segment_lines;
   logic [tts_pkg::MAX_DIGITS-1:0] digit_enable;
   logic [tts_pkg::POS_W-1:0]     digit_index;

   modport source (output valid, output segment_lines, output digit_enable,
                   output digit_index, input ready);
   modport sink   (input valid, input segment_lines, input digit_enable,
                   input digit_index, output ready);
endinterface

FILE: design/tts_convert.sv
// converts a sensor temperature word into eight digit codes
// depends on tts_pkg
module tts_convert (
   input  logic [tts_pkg::BYTE_W-1:0] reading_low,
   input  logic [tts_pkg::BYTE_W-1:0] reading_high,
   output tts_pkg::code_array_type    codes
);

   logic        negative;
   logic [15:0] word;
   logic [15:0] magnitude;
   logic [6:0]  int_part;
   logic        hundreds;
   logic [6:0]  rem;
   logic [14:0] tens_prod;
   logic [3:0]  tens;
   logic [6:0]  ones_full;
   logic [7:0]  frac_digits;

   // sign detect and two's complement magnitude
   assign negative  = |(reading_high & tts_pkg::SIGN_MASK);
   assign word      = {reading_high, reading_low};
   assign magnitude = negative ? (16'd0 - word) : word;
   assign int_part  = magnitude[10:4];

   // integer part to bcd, at most 127
   assign hundreds  = (int_part >= 7'd100);
   assign rem       = hundreds ? (int_part - 7'd100) : int_part;
   assign tens_prod = {8'd0, rem} * {7'd0, tts_pkg::DIV10_MUL};
   assign tens      = tens_prod[tts_pkg::DIV10_SHIFT +: 4];
   assign ones_full = rem - {tens, 3'b000} - {2'b00, tens, 1'b0};

   assign frac_digits = tts_pkg::frac_bcd(magnitude[3:0]);

   // place digits, minus sign just above the top integer digit
   always_comb begin
      for (int i = 0; i < tts_pkg::MAX_DIGITS; i++) begin
         codes[i] = tts_pkg::CODE_BLANK;
      end
      codes[0] = {1'b0, frac_digits[3:0]};
      codes[1] = {1'b0, frac_digits[7:4]};
      codes[2] = {1'b0, ones_full[3:0]};
      if (hundreds) begin
         codes[3] = {1'b0, tens};
         codes[4] = 5'd1;
         if (negative) begin
            codes[5] = tts_pkg::CODE_MINUS;
         end
      end else if (tens != 4'd0) begin
         codes[3] = {1'b0, tens};
         if (negative) begin
            codes[4] = tts_pkg::CODE_MINUS;
         end
      end else if (negative) begin
         codes[3] = tts_pkg::CODE_MINUS;
      end
   end

endmodule

FILE: design/tts_scan.sv
// digit code store, scan pointer and response register
// depends on tts_pkg and tts_rsp_if
module tts_scan #(
   parameter int DIGIT_COUNT = tts_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tts_pkg::scan_cmd_type   cmd,
   input  tts_pkg::code_array_type new_codes,
   tts_rsp_if.source               rsp
);

   localparam logic [tts_pkg::POS_W-1:0] LastPos = tts_pkg::POS_W'(DIGIT_COUNT - 1);

   tts_pkg::code_type                codes_ff [DIGIT_COUNT];
   tts_pkg::code_type                codes_in [DIGIT_COUNT];
   logic [tts_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic                             valid_ff, valid_in;
   logic [tts_pkg::SEG_W-1:0]        seg_ff, seg_in;
   logic [tts_pkg::MAX_DIGITS-1:0]   en_ff, en_in;
   logic [tts_pkg::POS_W-1:0]        idx_ff, idx_in;

   // code store update on a reading
   always_comb begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         codes_in[i] = cmd.load ? new_codes[i] : codes_ff[i];
      end
   end

   // scan pointer advance with wrap
   always_comb begin
      pos_in = pos_ff;
      if (cmd.tick) begin
         pos_in = (pos_ff == LastPos) ? '0 : pos_ff + 1'b1;
      end
   end

   // response register: load on tick, clear once the transfer completes
   always_comb begin
      valid_in = valid_ff;
      seg_in   = seg_ff;
      en_in    = en_ff;
      idx_in   = idx_ff;
      if (cmd.tick) begin
         valid_in = 1'b1;
         seg_in   = tts_pkg::glyph(codes_ff[pos_ff])
                  | ((pos_ff == tts_pkg::DP_DIGIT) ? tts_pkg::DP_SEG : '0);
         en_in    = ~(tts_pkg::MAX_DIGITS'(1) << pos_ff);
         idx_in   = pos_ff;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            codes_ff[i] <= tts_pkg::CODE_BLANK;
         end
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         codes_ff <= codes_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
      en_ff  <= en_in;
      idx_ff <= idx_in;
   end

   assign rsp.valid         = valid_ff;
   assign rsp.segment_lines = seg_ff;
   assign rsp.digit_enable  = en_ff;
   assign rsp.digit_index   = idx_ff;

endmodule

FILE: design/temperature_to_seven_segment_scanner_core.sv
// top level of the temperature to seven-segment scanner
// depends on tts_pkg, tts_req_if, tts_rsp_if, tts_convert, tts_scan
//
//   channel    dir   per transfer
//   req_chan   in    tick or reading (req_type, reading_low, reading_high)
//   rsp_chan   out   one digit drive (segment_lines, digit_enable, digit_index)
//
// one item per cycle while no tick is held by a stalled response; a tick passes the input
// register, then the response register, from which its response is valid; a reading
// passes the input register, then updates the digit store, and is seen by the next tick
// synchronous reset blanks all digits and sets the scan position to zero
// a stalled response holds the input register for ticks; readings still drain
`include "temperature_to_seven_segment_scanner_core_assert.svh"

module temperature_to_seven_segment_scanner_core #(
   parameter int DIGIT_COUNT = tts_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   tts_req_if.sink   req_chan,
   tts_rsp_if.source rsp_chan
);

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_type_ff, s1_type_in;
   logic [tts_pkg::BYTE_W-1:0] s1_low_ff, s1_low_in;
   logic [tts_pkg::BYTE_W-1:0] s1_high_ff, s1_high_in;
   logic                       out_free;
   logic                       s1_advance;
   logic                       accept;
   tts_pkg::scan_cmd_type      cmd;
   tts_pkg::code_array_type    new_codes;
   logic                       sel_one_hot;
   logic                       idx_in_range;
   logic                       dp_match;

   // stage advance: readings never wait, ticks need a free response slot
   assign out_free   = !rsp_chan.valid || rsp_chan.ready;
   assign s1_advance = s1_valid_ff
                     && ((s1_type_ff == tts_pkg::REQ_READING) || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept     = req_chan.valid && req_chan.ready;

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_type_in  = s1_type_ff;
      s1_low_in   = s1_low_ff;
      s1_high_in  = s1_high_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_type_in  = req_chan.req_type;
         s1_low_in   = req_chan.reading_low;
         s1_high_in  = req_chan.reading_high;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_type_ff <= s1_type_in;
      s1_low_ff  <= s1_low_in;
      s1_high_ff <= s1_high_in;
   end

   // commands to the scan stage
   assign cmd.load = s1_advance && (s1_type_ff == tts_pkg::REQ_READING);
   assign cmd.tick = s1_advance && (s1_type_ff == tts_pkg::REQ_TICK);

   tts_convert u_convert (
      .reading_low  (s1_low_ff),
      .reading_high (s1_high_ff),
      .codes        (new_codes)
   );

   tts_scan #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .new_codes (new_codes),
      .rsp       (rsp_chan)
   );

   // checks
   assign sel_one_hot  = ($countones(~rsp_chan.digit_enable) == 1)
                       && (rsp_chan.digit_enable[rsp_chan.digit_index] == 1'b0);
   assign idx_in_range = {1'b0, rsp_chan.digit_index} < 4'(DIGIT_COUNT);
   assign dp_match     = rsp_chan.segment_lines[7]
                       == (rsp_chan.digit_index == tts_pkg::DP_DIGIT);

   `TTS_ASSERT_NEXT(a_tick_gives_rsp, clock, reset, cmd.tick, rsp_chan.valid)
   `TTS_ASSERT_IMPLY(a_one_select, clock, reset, rsp_chan.valid, sel_one_hot)
   `TTS_ASSERT_IMPLY(a_index_range, clock, reset, rsp_chan.valid, idx_in_range)
   `TTS_ASSERT_IMPLY(a_dp_place, clock, reset, rsp_chan.valid, dp_match)

endmodule
